// File: src/vertex_view_transform_clip_project_top_defines.svh
// assertion macros shared by the vertex transform rtl
// expects clk and rst in the scope where a macro is used
`ifndef VERTEX_VIEW_TRANSFORM_CLIP_PROJECT_TOP_DEFINES_SVH
`define VERTEX_VIEW_TRANSFORM_CLIP_PROJECT_TOP_DEFINES_SVH

// property that must hold at every edge outside reset
`define VVTCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define VVTCP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/vvtcp_pkg.sv
// shared constants, register codes and divider item types
// no dependencies
package vvtcp_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int MATRIX_FRAC_DEF = 16;
  localparam int VIEW_W          = 24;
  localparam int HALF_W          = 11;
  localparam int SCREEN_W        = 16;
  localparam int CLIP_W          = 7;
  localparam int PLANE_OFF_W     = 40;
  localparam int REG_IDX_W       = 3;

  // quotient width: sized for the dividend |view| * half size * 16
  localparam int DIV_W = VIEW_W - 1 + HALF_W + 4;
  localparam int REM_W = VIEW_W - 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RIGHT_ROW,
    REG_UP_ROW,
    REG_FORWARD_ROW,
    REG_VIEW_ORIGIN,
    REG_FAR_SCREEN,
    REG_PLANE_WEIGHTS,
    REG_PLANE_OFFSET,
    REG_PLANE_ON
  } reg_idx_t;

  localparam int CLIP_RIGHT  = 0;
  localparam int CLIP_TOP    = 1;
  localparam int CLIP_LEFT   = 2;
  localparam int CLIP_BOTTOM = 3;
  localparam int CLIP_BEHIND = 4;
  localparam int CLIP_FAR    = 5;
  localparam int CLIP_PLANE  = 6;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t                 lx;
    div_lane_t                 ly;
    logic [REM_W-1:0]          divisor;
    logic signed [VIEW_W-1:0]  vx;
    logic signed [VIEW_W-1:0]  vy;
    logic signed [VIEW_W-1:0]  vz;
    logic [CLIP_W-1:0]         clip;
    logic [HALF_W-1:0]         w2;
    logic [HALF_W-1:0]         h2;
    logic                      proj;
  } div_item_t;

endpackage

// File: src/vvtcp_point_if.sv
// input channel: one world point per transaction
// depends on vvtcp_pkg
interface vvtcp_point_if #(
  parameter int COORD_WIDTH = vvtcp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] world_x;
  logic signed [COORD_WIDTH-1:0] world_y;
  logic signed [COORD_WIDTH-1:0] world_z;

  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

// File: src/vvtcp_result_if.sv
// output channel: transformed point, clip codes and screen position
// depends on vvtcp_pkg
interface vvtcp_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vvtcp_pkg::VIEW_W-1:0]    view_x;
  logic signed [vvtcp_pkg::VIEW_W-1:0]    view_y;
  logic signed [vvtcp_pkg::VIEW_W-1:0]    view_z;
  logic [vvtcp_pkg::CLIP_W-1:0]           clip_codes;
  logic signed [vvtcp_pkg::SCREEN_W-1:0]  screen_x;
  logic signed [vvtcp_pkg::SCREEN_W-1:0]  screen_y;
  logic                                   screen_valid;

  modport source (output valid, view_x, view_y, view_z, clip_codes, screen_x, screen_y,
                  screen_valid, input ready);
  modport sink (input valid, view_x, view_y, view_z, clip_codes, screen_x, screen_y,
                screen_valid, output ready);
endinterface

// File: src/vertex_view_transform_clip_project_top.sv
// path from point transaction to result: 5 front stages, one divider cell
// per quotient bit (38 cells), and the output register
// throughput: one point per cycle unless the output stalls; the divider
// chain and every stage advance independently, so bubbles collapse while
// the output is stalled; reset (synchronous, active high) empties the
// pipeline and zeroes all configuration registers
`include "vertex_view_transform_clip_project_top_defines.svh"
module vertex_view_transform_clip_project_top #(
  parameter int COORD_WIDTH      = vvtcp_pkg::COORD_WIDTH_DEF,
  parameter int MATRIX_FRAC_BITS = vvtcp_pkg::MATRIX_FRAC_DEF,
  localparam int EW_T  = MATRIX_FRAC_BITS + 2,
  localparam int CFG_A = (3 * EW_T > 3 * COORD_WIDTH) ? 3 * EW_T : 3 * COORD_WIDTH,
  localparam int CFG_B = (COORD_WIDTH + 2 * vvtcp_pkg::HALF_W > vvtcp_pkg::PLANE_OFF_W)
                         ? COORD_WIDTH + 2 * vvtcp_pkg::HALF_W : vvtcp_pkg::PLANE_OFF_W,
  localparam int CFG_W = (CFG_A > CFG_B) ? CFG_A : CFG_B
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vvtcp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  vvtcp_point_if.sink                     point,
  vvtcp_result_if.source                  result
);
  import vvtcp_pkg::*;

  div_item_t c_item  [DIV_W+1];
  logic      c_valid [DIV_W+1];
  logic      c_ready [DIV_W+1];

  vvtcp_front #(
    .COORD_WIDTH      (COORD_WIDTH),
    .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS),
    .CFG_W            (CFG_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pt         (point),
    .item       (c_item[0]),
    .item_valid (c_valid[0]),
    .item_ready (c_ready[0])
  );

  for (genvar k = 0; k < DIV_W; k++) begin : g_cell
    vvtcp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_item   (c_item[k]),
      .in_ready  (c_ready[k]),
      .out_valid (c_valid[k+1]),
      .out_item  (c_item[k+1]),
      .out_ready (c_ready[k+1])
    );
  end

  vvtcp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid[DIV_W]),
    .in_item  (c_item[DIV_W]),
    .in_ready (c_ready[DIV_W]),
    .res      (result)
  );

  `VVTCP_ASSERT_IMPL(a_noproj_zero, result.valid && !result.screen_valid,
    result.screen_x == '0 && result.screen_y == '0, "screen position set without projection")
  `VVTCP_ASSERT_IMPL(a_proj_depth, result.valid && result.screen_valid,
    !result.view_z[VIEW_W-1] && result.view_z != '0, "projection with non-positive depth")
  `VVTCP_ASSERT_IMPL(a_behind_noproj, result.valid && result.clip_codes[CLIP_BEHIND],
    !result.screen_valid, "point behind viewer marked projected")
  `VVTCP_ASSERT_IMPL(a_empty_ready, !result.valid && !c_valid[DIV_W],
    point.ready, "input stalled while pipeline tail is empty")

endmodule

// File: src/vvtcp_front.sv
// config registers, rotation, clip codes and divider setup (five stages)
// depends on vvtcp_pkg and vvtcp_point_if
module vvtcp_front #(
  parameter int COORD_WIDTH      = vvtcp_pkg::COORD_WIDTH_DEF,
  parameter int MATRIX_FRAC_BITS = vvtcp_pkg::MATRIX_FRAC_DEF,
  parameter int CFG_W            = 60
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vvtcp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  vvtcp_point_if.sink                     pt,
  output vvtcp_pkg::div_item_t            item,
  output logic                            item_valid,
  input  logic                            item_ready
);
  import vvtcp_pkg::*;

  localparam int EW    = MATRIX_FRAC_BITS + 2;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = DW + EW;
  localparam int AW    = PW + 2;
  localparam int FS_W  = COORD_WIDTH + 2 * HALF_W;
  localparam int PPW   = VIEW_W + EW;
  localparam int DPW   = ((PPW + 2 > PLANE_OFF_W) ? PPW + 2 : PLANE_OFF_W) + 1;
  localparam int NXW   = VIEW_W + HALF_W + 1;
  localparam int CMPW  = ((VIEW_W > COORD_WIDTH) ? VIEW_W : COORD_WIDTH) + 1;
  localparam longint THR = (longint'(5) << (8 + MATRIX_FRAC_BITS)) / 1000;
  localparam logic signed [DPW-1:0] NEG_THR = DPW'(-THR);
  localparam logic signed [AW-1:0]  VMAX = AW'((longint'(1) << (VIEW_W - 1)) - 1);
  localparam logic signed [AW-1:0]  VMIN = -VMAX - AW'(1);

  // configuration registers
  logic [3*EW-1:0]          right_row, up_row, forward_row, plane_weights;
  logic [3*COORD_WIDTH-1:0] view_origin;
  logic [FS_W-1:0]          far_screen;
  logic signed [PLANE_OFF_W-1:0] plane_offset;
  logic                     plane_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_row     <= '0;
      up_row        <= '0;
      forward_row   <= '0;
      view_origin   <= '0;
      far_screen    <= '0;
      plane_weights <= '0;
      plane_offset  <= '0;
      plane_on      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RIGHT_ROW:     right_row     <= cfg_data[3*EW-1:0];
        REG_UP_ROW:        up_row        <= cfg_data[3*EW-1:0];
        REG_FORWARD_ROW:   forward_row   <= cfg_data[3*EW-1:0];
        REG_VIEW_ORIGIN:   view_origin   <= cfg_data[3*COORD_WIDTH-1:0];
        REG_FAR_SCREEN:    far_screen    <= cfg_data[FS_W-1:0];
        REG_PLANE_WEIGHTS: plane_weights <= cfg_data[3*EW-1:0];
        REG_PLANE_OFFSET:  plane_offset  <= cfg_data[PLANE_OFF_W-1:0];
        REG_PLANE_ON:      plane_on      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic signed [EW-1:0]          mrow [3][3];
  logic signed [EW-1:0]          pw [3];
  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [COORD_WIDTH-1:0] wld [3];
  logic [COORD_WIDTH-1:0]        far_z;
  logic [HALF_W-1:0]             w2, h2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mrow[0][i] = right_row[i*EW +: EW];
      mrow[1][i] = up_row[i*EW +: EW];
      mrow[2][i] = forward_row[i*EW +: EW];
      pw[i]      = plane_weights[i*EW +: EW];
      org[i]     = view_origin[i*COORD_WIDTH +: COORD_WIDTH];
    end
    wld[0] = pt.world_x;
    wld[1] = pt.world_y;
    wld[2] = pt.world_z;
    far_z  = far_screen[COORD_WIDTH-1:0];
    w2     = far_screen[COORD_WIDTH +: HALF_W];
    h2     = far_screen[COORD_WIDTH + HALF_W +: HALF_W];
  end

  // stage valids and the ready chain
  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  assign r5 = !v5 || item_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign pt.ready   = r1;
  assign item_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= pt.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // stage 1: offset from view origin
  logic signed [DW-1:0] d [3];
  always_ff @(posedge clk) begin
    if (r1) begin
      for (int i = 0; i < 3; i++) d[i] <= DW'(wld[i]) - DW'(org[i]);
    end
  end

  // stage 2: nine products
  logic signed [PW-1:0] prod [3][3];
  always_ff @(posedge clk) begin
    if (r2) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) prod[r][i] <= PW'(d[i]) * PW'(mrow[r][i]);
      end
    end
  end

  // stage 3: row sums, floor shift and saturate
  logic signed [AW-1:0]     acc [3];
  logic signed [AW-1:0]     shd [3];
  logic signed [VIEW_W-1:0] vw [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(prod[r][0]) + AW'(prod[r][1]) + AW'(prod[r][2]);
      shd[r] = acc[r] >>> MATRIX_FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      for (int r = 0; r < 3; r++) begin
        if (shd[r] > VMAX)      vw[r] <= VMAX[VIEW_W-1:0];
        else if (shd[r] < VMIN) vw[r] <= VMIN[VIEW_W-1:0];
        else                    vw[r] <= shd[r][VIEW_W-1:0];
      end
    end
  end

  // stage 4: clip compares, plane products, projection numerators
  logic signed [VIEW_W:0]   nz;
  logic signed [CMPW-1:0]   far_c;
  logic [CLIP_W-1:0]        clip_c;
  logic signed [PPW-1:0]    pp [3];
  logic signed [NXW-1:0]    nx, ny;
  logic signed [VIEW_W-1:0] vx4, vy4, vz4;
  logic [CLIP_W-1:0]        clip4;
  logic                     proj4;
  logic [HALF_W-1:0]        w2_4, h2_4;

  always_comb begin
    nz     = -((VIEW_W+1)'(vw[2]));
    far_c  = signed'(CMPW'({1'b0, far_z}));
    clip_c = '0;
    clip_c[CLIP_RIGHT]  = vw[0] > vw[2];
    clip_c[CLIP_TOP]    = vw[1] > vw[2];
    clip_c[CLIP_LEFT]   = (VIEW_W+1)'(vw[0]) < nz;
    clip_c[CLIP_BOTTOM] = (VIEW_W+1)'(vw[1]) < nz;
    clip_c[CLIP_BEHIND] = vw[2][VIEW_W-1];
    clip_c[CLIP_FAR]    = CMPW'(vw[2]) > far_c;
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      for (int i = 0; i < 3; i++) pp[i] <= PPW'(vw[i]) * PPW'(pw[i]);
      nx    <= NXW'(vw[0]) * NXW'(signed'({1'b0, w2}));
      ny    <= NXW'(vw[1]) * NXW'(signed'({1'b0, h2}));
      vx4   <= vw[0];
      vy4   <= vw[1];
      vz4   <= vw[2];
      clip4 <= clip_c;
      proj4 <= !vw[2][VIEW_W-1] && (vw[2] != '0);
      w2_4  <= w2;
      h2_4  <= h2;
    end
  end

  // stage 5: plane distance and divider operands
  logic signed [DPW-1:0] dp;
  logic [NXW-1:0]        mx, my;
  div_item_t             item_c;

  always_comb begin
    dp = DPW'(pp[0]) + DPW'(pp[1]) + DPW'(pp[2]) - DPW'(plane_offset);
    mx = nx[NXW-1] ? NXW'(-nx) : NXW'(nx);
    my = ny[NXW-1] ? NXW'(-ny) : NXW'(ny);
    item_c.lx.rem = '0;
    item_c.lx.num = {mx[DIV_W-5:0], 4'b0000};
    item_c.lx.neg = nx[NXW-1];
    item_c.ly.rem = '0;
    item_c.ly.num = {my[DIV_W-5:0], 4'b0000};
    item_c.ly.neg = ny[NXW-1];
    item_c.divisor = vz4[REM_W-1:0];
    item_c.vx   = vx4;
    item_c.vy   = vy4;
    item_c.vz   = vz4;
    item_c.clip = clip4;
    item_c.clip[CLIP_PLANE] = plane_on && (dp < NEG_THR);
    item_c.w2   = w2_4;
    item_c.h2   = h2_4;
    item_c.proj = proj4;
  end

  always_ff @(posedge clk) begin
    if (r5) item <= item_c;
  end

endmodule

// File: src/vvtcp_div_cell.sv
// one restoring-division cell: one quotient bit for x and y per item
// depends on vvtcp_pkg
module vvtcp_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  vvtcp_pkg::div_item_t in_item,
  output logic                 in_ready,
  output logic                 out_valid,
  output vvtcp_pkg::div_item_t out_item,
  input  logic                 out_ready
);
  import vvtcp_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t a, input logic [REM_W-1:0] dv);
    logic [REM_W:0] t;
    logic           ge;
    div_lane_t      o;
    t  = {a.rem, a.num[DIV_W-1]};
    ge = t >= {1'b0, dv};
    o.rem = ge ? REM_W'(t - {1'b0, dv}) : t[REM_W-1:0];
    o.num = {a.num[DIV_W-2:0], ge};
    o.neg = a.neg;
    return o;
  endfunction

  div_item_t nxt;
  always_comb begin
    nxt    = in_item;
    nxt.lx = div_step(in_item.lx, in_item.divisor);
    nxt.ly = div_step(in_item.ly, in_item.divisor);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_item <= nxt;
  end

endmodule

// File: src/vvtcp_back.sv
// quotient sign, screen offset and saturation into the output register
// depends on vvtcp_pkg and vvtcp_result_if
module vvtcp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  vvtcp_pkg::div_item_t in_item,
  output logic                 in_ready,
  vvtcp_result_if.source       res
);
  import vvtcp_pkg::*;

  localparam int SW = DIV_W + 2;
  localparam logic signed [SW-1:0] SMAX = SW'((longint'(1) << (SCREEN_W - 1)) - 1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic signed [SW-1:0]       qx, qy, sx, sy;
  logic signed [SCREEN_W-1:0] sx_sat, sy_sat;

  always_comb begin
    qx = in_item.lx.neg ? -SW'({1'b0, in_item.lx.num}) : SW'({1'b0, in_item.lx.num});
    qy = in_item.ly.neg ? -SW'({1'b0, in_item.ly.num}) : SW'({1'b0, in_item.ly.num});
    sx = SW'({1'b0, in_item.w2, 4'b0000}) + qx;
    sy = SW'({1'b0, in_item.h2, 4'b0000}) - qy;
    if (sx > SMAX)      sx_sat = SMAX[SCREEN_W-1:0];
    else if (sx < SMIN) sx_sat = SMIN[SCREEN_W-1:0];
    else                sx_sat = sx[SCREEN_W-1:0];
    if (sy > SMAX)      sy_sat = SMAX[SCREEN_W-1:0];
    else if (sy < SMIN) sy_sat = SMIN[SCREEN_W-1:0];
    else                sy_sat = sy[SCREEN_W-1:0];
    if (!in_item.proj) begin
      sx_sat = '0;
      sy_sat = '0;
    end
  end

  assign in_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_ready) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      res.view_x       <= in_item.vx;
      res.view_y       <= in_item.vy;
      res.view_z       <= in_item.vz;
      res.clip_codes   <= in_item.clip;
      res.screen_x     <= sx_sat;
      res.screen_y     <= sy_sat;
      res.screen_valid <= in_item.proj;
    end
  end

endmodule
